### sv/open_address_hash_table_unit_defines.svh
// Assertion macros for the open-address hash table unit.
// Used by the top level; expects clk and rst_n in scope.
`ifndef OPEN_ADDRESS_HASH_TABLE_UNIT_DEFINES_SVH
`define OPEN_ADDRESS_HASH_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define OAHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define OAHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/oaht_pkg.sv
// Shared types and constants for the open-address hash table unit.
// No dependencies.
package oaht_pkg;

    localparam int CMD_W   = 2;
    localparam int KEY_W   = 32;
    localparam int HASH_W  = 32;
    localparam int VAL_W   = 64;
    localparam int CNT_W   = 9;
    localparam int LIMIT_W = 8;
    localparam int TAG_W   = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd192;

    localparam logic [CMD_W-1:0] CMD_GET = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;

    localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
    localparam logic [TAG_W-1:0] TAG_LIVE  = 2'd1;
    localparam logic [TAG_W-1:0] TAG_TOMB  = 2'd2;

    // hash bits folded into the remainder per cycle
    localparam int MOD_STEP_BITS = 4;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [KEY_W-1:0]  key;
        logic [HASH_W-1:0] hash;
        logic [VAL_W-1:0]  value;
    } slot_t;

    typedef struct packed {
        logic             flag;
        logic [VAL_W-1:0] value;
        logic             status;
    } result_t;

endpackage

### sv/oaht_hmod.sv
// Home-slot unit: key_hash modulo CAPACITY.
// Depends on oaht_pkg. Power-of-two capacity is a mask, otherwise restoring reduction.
module oaht_hmod
    import oaht_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [HASH_W-1:0]           hash,
    output logic                        done,
    output logic [$clog2(CAPACITY)-1:0] rem
);

    localparam int  AW   = $clog2(CAPACITY);
    localparam bit  POW2 = (CAPACITY & (CAPACITY - 1)) == 0;

    generate
        if (POW2) begin : g_mask
            logic          done_reg;
            logic [AW-1:0] rem_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg <= hash[AW-1:0];
                end
            end

            assign done = done_reg;
            assign rem  = rem_reg;
        end
        else begin : g_reduce
            localparam int STEPS = HASH_W / MOD_STEP_BITS;
            localparam int SW    = $clog2(STEPS);
            localparam logic [AW:0]   CAP_W    = (AW+1)'(CAPACITY);
            localparam logic [SW-1:0] LAST_STEP = SW'(STEPS - 1);

            logic              busy_reg;
            logic              done_reg;
            logic [SW-1:0]     step_reg;
            logic [HASH_W-1:0] shift_reg;
            logic [AW-1:0]     rem_reg;
            logic [AW-1:0]     rem_next;

            // shift in a few hash bits, subtract capacity when the partial overflows it
            always_comb
            begin
                logic [AW:0]   t;
                logic [AW-1:0] r;
                r = rem_reg;
                for (int i = 0; i < MOD_STEP_BITS; i++)
                begin
                    t = {r, shift_reg[HASH_W-1-i]};
                    if (t >= CAP_W)
                    begin
                        t = t - CAP_W;
                    end
                    r = t[AW-1:0];
                end
                rem_next = r;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    step_reg <= '0;
                end
                else
                begin
                    done_reg <= busy_reg && (step_reg == LAST_STEP);
                    if (start)
                    begin
                        busy_reg <= 1'b1;
                        step_reg <= '0;
                    end
                    else if (busy_reg)
                    begin
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == LAST_STEP)
                        begin
                            busy_reg <= 1'b0;
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    shift_reg <= hash;
                    rem_reg   <= '0;
                end
                else if (busy_reg)
                begin
                    shift_reg <= shift_reg << MOD_STEP_BITS;
                    rem_reg   <= rem_next;
                end
            end

            assign done = done_reg;
            assign rem  = rem_reg;
        end
    endgenerate

endmodule

### sv/open_address_hash_table_unit.sv
// Top level of the open-address hash table: sequencer, slot memory, result register.
// Depends on oaht_pkg, oaht_hmod and open_address_hash_table_unit_defines.svh.
//
//  channel  dir  handshake             payload
//  cfg      in   cfg_valid/cfg_ready   cfg_data (load limit)
//  in       in   in_valid/in_ready     cmd, key_handle, key_digest, new_value
//  out      out  out_valid/out_ready   flag, read_value, status
//
// One item at a time. A hit or stop at the home slot passes the hash, check and response
// states; out_valid rises as the state returns to idle. Each further slot probed adds a read
// and a check state (read and check on the one slot memory port).
// A capacity that is not a power of two adds a restoring reduction for the home slot.
// After reset the tags are swept to empty, with in_ready low.
// A beat waiting on out does not block the next item until its result is ready.
`include "open_address_hash_table_unit_defines.svh"

module open_address_hash_table_unit
    import oaht_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [KEY_W-1:0]   key_handle,
    input  logic [HASH_W-1:0]  key_digest,
    input  logic [VAL_W-1:0]   new_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               flag,
    output logic [VAL_W-1:0]   read_value,
    output logic               status
);

    localparam int AW = $clog2(CAPACITY);
    localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;
    localparam logic [2:0] ST_RESP  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [HASH_W-1:0]  hash_reg, hash_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [AW-1:0]      visit_reg, visit_next;
    logic               tomb_seen_reg, tomb_seen_next;
    logic [AW-1:0]      tomb_at_reg, tomb_at_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    result_t            res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    slot_t              mem [CAPACITY];
    slot_t              rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    slot_t              wr_data;

    logic               mod_start;
    logic               mod_done;
    logic [AW-1:0]      mod_rem;

    logic               accept;
    logic [CNT_W:0]     count_inc;
    logic               refuse;
    logic               is_live;
    logic               is_tomb;
    logic               is_match;
    logic               tomb_any;
    logic [AW-1:0]      tomb_pos;
    logic [AW-1:0]      addr_inc;
    logic               wr_phase;

    oaht_hmod #(
        .CAPACITY (CAPACITY)
    ) u_hmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .hash  (key_digest),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;

    assign count_inc = {1'b0, count_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign refuse    = count_inc > {{(CNT_W + 1 - LIMIT_W){1'b0}}, limit_reg};

    assign is_live  = rd_data_reg.tag == TAG_LIVE;
    assign is_tomb  = rd_data_reg.tag == TAG_TOMB;
    assign is_match = is_live && (rd_data_reg.key == key_reg) && (rd_data_reg.hash == hash_reg);
    assign tomb_any = tomb_seen_reg || is_tomb;
    assign tomb_pos = tomb_seen_reg ? tomb_at_reg : addr_reg;
    assign addr_inc = (addr_reg == LAST_ADDR) ? '0 : addr_reg + 1'b1;

    assign rd_addr  = (state_reg == ST_HASH) ? mod_rem : addr_reg;
    assign wr_phase = (state_reg == ST_CLEAR) || (state_reg == ST_CHECK);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        hash_next      = hash_reg;
        val_next       = val_reg;
        addr_next      = addr_reg;
        visit_next     = visit_reg;
        tomb_seen_next = tomb_seen_reg;
        tomb_at_next   = tomb_at_reg;
        count_next     = count_reg;
        clr_addr_next  = clr_addr_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        mod_start      = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_data        = rd_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data.tag   = TAG_EMPTY;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next       = cmd;
                    key_next       = key_handle;
                    hash_next      = key_digest;
                    val_next       = new_value;
                    visit_next     = '0;
                    tomb_seen_next = 1'b0;
                    res_next       = '0;
                    case (cmd)
                        CMD_GET, CMD_DEL:
                        begin
                            mod_start  = 1'b1;
                            state_next = ST_HASH;
                        end
                        CMD_SET:
                        begin
                            if (refuse)
                            begin
                                res_next.status = 1'b1;
                                state_next      = ST_RESP;
                            end
                            else
                            begin
                                mod_start  = 1'b1;
                                state_next = ST_HASH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_HASH:
            begin
                // home slot read goes out this cycle straight from the remainder
                if (mod_done)
                begin
                    addr_next  = mod_rem;
                    state_next = ST_CHECK;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (is_match)
                begin
                    state_next = ST_RESP;
                    case (cmd_reg)
                        CMD_GET:
                        begin
                            res_next.flag  = 1'b1;
                            res_next.value = rd_data_reg.value;
                        end
                        CMD_SET:
                        begin
                            wr_en         = 1'b1;
                            wr_data.value = val_reg;
                        end
                        CMD_DEL:
                        begin
                            wr_en         = 1'b1;
                            wr_data.tag   = TAG_TOMB;
                            res_next.flag = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (!is_live && !is_tomb)
                begin
                    // empty slot ends the run
                    state_next = ST_RESP;
                    if (cmd_reg == CMD_SET)
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = tomb_pos;
                        wr_data       = {TAG_LIVE, key_reg, hash_reg, val_reg};
                        res_next.flag = 1'b1;
                        if (!tomb_seen_reg)
                        begin
                            count_next = count_inc[CNT_W-1:0];
                        end
                    end
                end
                else
                begin
                    if (is_tomb && !tomb_seen_reg)
                    begin
                        tomb_seen_next = 1'b1;
                        tomb_at_next   = addr_reg;
                    end
                    if (visit_reg == LAST_ADDR)
                    begin
                        // whole table visited without an empty slot
                        state_next = ST_RESP;
                        if (cmd_reg == CMD_SET)
                        begin
                            if (tomb_any)
                            begin
                                wr_en         = 1'b1;
                                wr_addr       = tomb_pos;
                                wr_data       = {TAG_LIVE, key_reg, hash_reg, val_reg};
                                res_next.flag = 1'b1;
                            end
                            else
                            begin
                                res_next.status = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        visit_next = visit_reg + 1'b1;
                        addr_next  = addr_inc;
                        state_next = ST_READ;
                    end
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            count_reg     <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
            tomb_seen_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            tomb_seen_reg <= tomb_seen_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        hash_reg    <= hash_next;
        val_reg     <= val_next;
        addr_reg    <= addr_next;
        visit_reg   <= visit_next;
        tomb_at_reg <= tomb_at_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    // slot memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign out_valid  = out_valid_reg;
    assign flag       = out_reg.flag;
    assign read_value = out_reg.value;
    assign status     = out_reg.status;

    `OAHT_ASSERT_NOW(a_wr_state, wr_en, wr_phase, "slot write outside clear or check")
    `OAHT_ASSERT_NOW(a_mod_done, mod_done, state_reg == ST_HASH, "remainder out of phase")
    `OAHT_ASSERT_NEXT(a_cnt_hold, state_reg != ST_CHECK, $stable(count_reg), "count moved")
    `OAHT_ASSERT_NOW(a_cnt_range, 1'b1, count_reg[CNT_W-1] == 1'b0, "count overflow")

endmodule

### tb/sv/open_address_hash_table_unit_tb.sv
// Bench for open_address_hash_table_unit: directed and random get/set/delete beats,
// load limit writes between phases, results checked against a slot array kept here.
// Depends on oaht_pkg and the unit's RTL.
module open_address_hash_table_unit_tb;
    import oaht_pkg::*;

    localparam int SLOTS = 256;
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
    localparam int PHASES = 5;
    localparam int PHASE_ITEMS = 266;
    localparam int CALM_TAIL = 150;
    localparam int SETTLE_CYCLES = 600;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int MAX_PRINTS = 40;
    localparam int POOL_MAX = 400;

    typedef struct {
        bit                 is_limit;
        logic [LIMIT_W-1:0] limit;
        logic [CMD_W-1:0]   op;
        logic [KEY_W-1:0]   handle;
        logic [HASH_W-1:0]  hash_val;
        logic [VAL_W-1:0]   value;
    } request_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [CMD_W-1:0]   cmd = CMD_GET;
    logic [KEY_W-1:0]   key_handle = '0;
    logic [HASH_W-1:0]  key_digest = '0;
    logic [VAL_W-1:0]   new_value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               flag;
    logic [VAL_W-1:0]   read_value;
    logic               status;

    // bench copy of the table
    logic [TAG_W-1:0]   tag_mem [SLOTS];
    logic [KEY_W-1:0]   key_mem [SLOTS];
    logic [HASH_W-1:0]  hash_mem [SLOTS];
    logic [VAL_W-1:0]   val_mem [SLOTS];
    int unsigned        occupied = 0;
    logic [LIMIT_W-1:0] limit_now = LIMIT_RESET;

    request_t           backlog [$];
    result_t            answers_due [$];
    logic [KEY_W-1:0]   pool_handle [$];
    logic [HASH_W-1:0]  pool_hash [$];

    // accept counts kept by the sample side, copies kept by the drive side
    int unsigned in_accepts = 0;
    int unsigned in_seen = 0;
    int unsigned cfg_seen = 0;
    int unsigned in_gap = 0;
    int unsigned out_gap = 0;
    int unsigned idle_pct = 25;
    int unsigned cycle_count = 0;
    int unsigned bad_count = 0;
    int unsigned checked = 0;
    int unsigned refusals = 0;
    int unsigned limit_writes = 0;
    int unsigned op_count [4] = '{0, 0, 0, 0};

    open_address_hash_table_unit #(.CAPACITY(SLOTS)) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .key_handle (key_handle),
        .key_digest (key_digest),
        .new_value  (new_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .flag       (flag),
        .read_value (read_value),
        .status     (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_bad(input string what);
        bad_count++;
        if (bad_count <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // One operation on the bench table; returns the result the unit must give.
    function automatic result_t apply_to_table(input logic [CMD_W-1:0] op,
                                               input logic [KEY_W-1:0] handle,
                                               input logic [HASH_W-1:0] hash_val,
                                               input logic [VAL_W-1:0] value);
        result_t     r;
        int unsigned at, n, hit_at, tomb_at, empty_at;
        bit          hit, have_tomb, have_empty, over;
        r = '0;
        hit = 1'b0;
        have_tomb = 1'b0;
        have_empty = 1'b0;
        hit_at = 0;
        tomb_at = 0;
        empty_at = 0;
        over = (occupied + 1 > int'(limit_now));
        if (op == CMD_GET || op == CMD_DEL || (op == CMD_SET && !over))
        begin
            at = hash_val % SLOTS;
            for (n = 0; n < SLOTS && !hit && !have_empty; n++)
            begin
                if (tag_mem[at] == TAG_EMPTY)
                begin
                    have_empty = 1'b1;
                    empty_at = at;
                end
                else if (tag_mem[at] == TAG_TOMB)
                begin
                    if (!have_tomb)
                    begin
                        have_tomb = 1'b1;
                        tomb_at = at;
                    end
                end
                else if (hash_mem[at] == hash_val && key_mem[at] == handle)
                begin
                    hit = 1'b1;
                    hit_at = at;
                end
                at = (at + 1) % SLOTS;
            end
        end
        case (op)
            CMD_GET:
                if (hit)
                begin
                    r.flag = 1'b1;
                    r.value = val_mem[hit_at];
                end
            CMD_SET:
                if (over)
                    r.status = 1'b1;
                else if (hit)
                    val_mem[hit_at] = value;
                else if (have_tomb || have_empty)
                begin
                    // first tombstone wins over the empty slot
                    at = have_tomb ? tomb_at : empty_at;
                    if (!have_tomb)
                        occupied++;
                    tag_mem[at] = TAG_LIVE;
                    key_mem[at] = handle;
                    hash_mem[at] = hash_val;
                    val_mem[at] = value;
                    r.flag = 1'b1;
                end
                else
                    r.status = 1'b1;
            CMD_DEL:
                if (hit)
                begin
                    tag_mem[hit_at] = TAG_TOMB;
                    r.flag = 1'b1;
                end
            default: ;
        endcase
        if (r.status)
            refusals++;
        return r;
    endfunction

    task automatic push_op(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] handle,
                           input logic [HASH_W-1:0] hash_val, input logic [VAL_W-1:0] value);
        request_t q;
        q.is_limit = 1'b0;
        q.limit = '0;
        q.op = op;
        q.handle = handle;
        q.hash_val = hash_val;
        q.value = value;
        backlog.push_back(q);
    endtask

    task automatic push_limit(input logic [LIMIT_W-1:0] limit);
        request_t q;
        q.is_limit = 1'b1;
        q.limit = limit;
        q.op = CMD_GET;
        q.handle = '0;
        q.hash_val = '0;
        q.value = '0;
        backlog.push_back(q);
    endtask

    task automatic remember_key(input logic [KEY_W-1:0] handle, input logic [HASH_W-1:0] hash_val);
        int unsigned k;
        if (pool_handle.size() < POOL_MAX)
        begin
            pool_handle.push_back(handle);
            pool_hash.push_back(hash_val);
        end
        else
        begin
            k = $urandom_range(POOL_MAX - 1);
            pool_handle[k] = handle;
            pool_hash[k] = hash_val;
        end
    endtask

    // sample side: result checks, prediction on accepted beats, limit writes
    always @(posedge clk)
    begin : watch
        result_t want;
        cycle_count++;
        if (cycle_count % 256 == 0)
        begin
            case ($urandom_range(3))
                0: idle_pct = 0;
                1: idle_pct = 8;
                2: idle_pct = 25;
                default: idle_pct = 50;
            endcase
        end
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                checked++;
                if (answers_due.size() == 0)
                    report_bad("result beat with nothing outstanding");
                else
                begin
                    want = answers_due.pop_front();
                    if (flag !== want.flag)
                        report_bad($sformatf("flag %0b, want %0b", flag, want.flag));
                    if (read_value !== want.value)
                        report_bad($sformatf("read_value %h, want %h", read_value, want.value));
                    if (status !== want.status)
                        report_bad($sformatf("status %0b, want %0b", status, want.status));
                end
            end
            if (in_valid && in_ready)
            begin
                answers_due.push_back(apply_to_table(cmd, key_handle, key_digest, new_value));
                op_count[cmd]++;
                in_accepts++;
            end
            if (cfg_valid && cfg_ready)
            begin
                limit_now = cfg_data;
                limit_writes++;
            end
        end
    end

    // drive side: input and limit beats from the backlog, result-side stalls
    always @(negedge clk)
    begin : drive
        request_t head;
        bit       in_busy, cfg_busy, nv_in, nv_cfg, calm;
        if (rst_n)
        begin
            calm = (backlog.size() <= CALM_TAIL);
            in_busy = in_valid && (in_accepts == in_seen);
            cfg_busy = cfg_valid && (limit_writes == cfg_seen);
            in_seen = in_accepts;
            cfg_seen = limit_writes;
            nv_in = in_busy;
            nv_cfg = cfg_busy;
            if (!in_busy && !cfg_busy && backlog.size() != 0)
            begin
                if (in_gap != 0)
                    in_gap--;
                else if (!calm && $urandom_range(99) < idle_pct)
                    in_gap = $urandom_range(16);
                else
                begin
                    head = backlog[0];
                    if (head.is_limit)
                    begin
                        // limit changes only with nothing in flight
                        if (answers_due.size() == 0)
                        begin
                            void'(backlog.pop_front());
                            cfg_data <= head.limit;
                            nv_cfg = 1'b1;
                        end
                    end
                    else
                    begin
                        void'(backlog.pop_front());
                        cmd <= head.op;
                        key_handle <= head.handle;
                        key_digest <= head.hash_val;
                        new_value <= head.value;
                        nv_in = 1'b1;
                    end
                end
            end
            in_valid <= nv_in;
            cfg_valid <= nv_cfg;
            if (out_gap != 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(99) < idle_pct)
            begin
                out_gap = $urandom_range(16);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : run
        int unsigned      p, i, k, roll;
        int unsigned      phase_limit [PHASES];
        logic [CMD_W-1:0] op;
        logic [KEY_W-1:0] h;
        logic [HASH_W-1:0] hv;
        logic [31:0]      tmp;
        logic [7:0]       home;
        bit               timed_out;

        for (i = 0; i < SLOTS; i++)
            tag_mem[i] = TAG_EMPTY;
        phase_limit = '{24, 96, 255, 150, 255};

        // directed: hit, miss, update, collisions, tombstones, wrap at the last slot
        push_op(CMD_SET, 32'h1, 32'h0000_0010, '0);
        push_op(CMD_GET, 32'h1, 32'h0000_0010, {$urandom, $urandom});
        push_op(CMD_SET, 32'h1, 32'h0000_0010, '1);
        push_op(CMD_GET, 32'h1, 32'h0000_0010, '0);
        push_op(CMD_GET, 32'h1, 32'h1000_0010, '0);        // same handle, other hash
        push_op(CMD_SET, 32'h2, 32'h0000_0010, 64'h0123_4567_89AB_CDEF);
        push_op(CMD_GET, 32'h2, 32'h0000_0010, '0);
        push_op(CMD_DEL, 32'h1, 32'h0000_0010, '0);
        push_op(CMD_DEL, 32'h1, 32'h0000_0010, '0);        // already gone
        push_op(CMD_GET, 32'h2, 32'h0000_0010, '0);        // past the tombstone
        push_op(CMD_SET, 32'h3, 32'hAB00_0010, 64'hFEDC_BA98_7654_3210);
        push_op(CMD_GET, 32'h3, 32'hAB00_0010, '0);
        push_op(CMD_SET, 32'h0, 32'hFFFF_FFFF, {$urandom, $urandom});
        push_op(CMD_SET, 32'hFFFF_FFFF, 32'h0000_00FF, '1);
        push_op(CMD_GET, 32'hFFFF_FFFF, 32'h0000_00FF, '0);
        push_op(CMD_GET, 32'h0, 32'hFFFF_FFFF, '0);
        push_op(CMD_NONE, {$urandom}, {$urandom}, {$urandom, $urandom});
        push_op(CMD_DEL, 32'h0, 32'hFFFF_FFFF, '0);
        push_op(CMD_GET, 32'hFFFF_FFFF, 32'h0000_00FF, '0);
        push_op(CMD_NONE, '1, '1, '1);
        // load limit zero refuses every set, present keys too
        push_limit(8'd0);
        push_op(CMD_SET, 32'h2, 32'h0000_0010, '1);
        push_op(CMD_GET, 32'h2, 32'h0000_0010, '0);
        push_limit(8'd1);
        push_op(CMD_SET, 32'h7, 32'h0000_0020, '1);
        push_limit(8'd5);
        push_op(CMD_SET, 32'h8, 32'h0000_0021, {$urandom, $urandom});
        push_op(CMD_SET, 32'h9, 32'h0000_0022, {$urandom, $urandom});
        remember_key(32'h2, 32'h0000_0010);
        remember_key(32'h3, 32'hAB00_0010);
        remember_key(32'hFFFF_FFFF, 32'h0000_00FF);
        remember_key(32'h8, 32'h0000_0021);

        for (p = 0; p < PHASES; p++)
        begin
            push_limit(phase_limit[p][7:0]);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                roll = $urandom_range(99);
                if (roll < 4)
                    op = CMD_NONE;
                else if (roll < 44)
                    op = CMD_SET;
                else if (roll < 74)
                    op = CMD_GET;
                else
                    op = CMD_DEL;
                roll = $urandom_range(99);
                k = $urandom_range(pool_handle.size() - 1);
                if (roll < 62)
                begin
                    h = pool_handle[k];
                    hv = pool_hash[k];
                end
                else if (roll < 69)
                begin
                    // same handle, same home slot, different hash
                    h = pool_handle[k];
                    hv = pool_hash[k] ^ (({$urandom} | 32'h100) & 32'hFFFF_FF00);
                end
                else if (roll < 75)
                begin
                    h = pool_handle[k] ^ ({$urandom} | 32'h1);
                    hv = pool_hash[k];
                end
                else
                begin
                    h = ($urandom_range(19) == 0) ? '0 : $urandom;
                    tmp = $urandom;
                    // half the fresh keys crowd around the wrap point
                    home = $urandom_range(1) ? 8'($urandom_range(255)) : 8'(248 + $urandom_range(15));
                    hv = {tmp[31:8], home};
                    remember_key(h, hv);
                end
                push_op(op, h, hv, {$urandom, $urandom});
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while ((backlog.size() != 0 || in_valid || cfg_valid || answers_due.size() != 0)
               && cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        timed_out = (cycle_count >= CYCLE_LIMIT);
        if (!timed_out)
            repeat (SETTLE_CYCLES) @(posedge clk);

        if (timed_out)
        begin
            $display("timed out after %0d cycles, %0d results outstanding",
                     cycle_count, answers_due.size());
            $display("FAIL");
        end
        else
        begin
            $display("covered %0d gets, %0d sets, %0d deletes, %0d unknown ops, %0d limit writes",
                     op_count[CMD_GET], op_count[CMD_SET], op_count[CMD_DEL],
                     op_count[CMD_NONE], limit_writes);
            $display("%0d results checked, %0d sets refused, %0d slots used, %0d mismatches",
                     checked, refusals, occupied, bad_count);
            if (bad_count == 0)
                $display("PASS");
            else
                $display("FAIL");
        end
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/oaht_pkg.sv
sv/oaht_hmod.sv
sv/open_address_hash_table_unit.sv
tb/sv/open_address_hash_table_unit_tb.sv
